[rtl/otr_pkg.sv]
`timescale 1ns / 1ps
package otr_pkg;
  localparam int VW = 5;   // vertex index width (fixed by fields)
  localparam int CW = 6;   // count width

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROOT   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLR,
    S_ZSCAN,
    S_BFS,
    S_SHIFT,
    S_FIX,
    S_EMIT,
    S_REPORT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;       // capture input beat
    logic clr_all;    // clear edges, degrees, parents
    logic ins;        // append edge
    logic clr_lbl;    // clear parents and visited, seed frontier
    logic zscan;      // one step of vertex 0 scan
    logic bfs;        // one step of search
    logic shift;      // one step of compaction
    logic fix;        // write set aside edge at end
    logic emit;       // load one result into output register
    logic report;     // load single report result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ins_ok;
    logic root_bad;
    logic zscan_done;
    logic bfs_done;
    logic do_shift;
    logic shift_done;
    logic emit_last;
    logic out_free;
  } stat_t;
endpackage

[rtl/otr_ctrl.sv]
`timescale 1ns / 1ps
module otr_ctrl
  import otr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  opcode_t op,
  input  stat_t   st,
  output logic    in_ready,
  output cmd_t    cmd
);
  state_t state, state_next;
  opcode_t op_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op_q  <= OP_NONE;
    end else begin
      state <= state_next;
      if (in_valid && in_ready) op_q <= op;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = (op == OP_ROOT) ? S_CLR : S_REPORT;
      end
      S_CLR:    state_next = st.root_bad ? S_EMIT : S_ZSCAN;
      S_ZSCAN:  if (st.zscan_done) state_next = S_BFS;
      S_BFS: begin
        if (st.bfs_done) state_next = st.do_shift ? S_SHIFT : S_EMIT;
      end
      S_SHIFT:  if (st.shift_done) state_next = S_FIX;
      S_FIX:    state_next = S_EMIT;
      S_EMIT:   if (st.out_free && st.emit_last) state_next = S_IDLE;
      S_REPORT: if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    cmd.take = in_valid && (state == S_IDLE);
    unique case (state)
      S_IDLE:   ;
      S_CLR:    cmd.clr_lbl = 1'b1;
      S_ZSCAN:  cmd.zscan = 1'b1;
      S_BFS:    cmd.bfs = 1'b1;
      S_SHIFT:  cmd.shift = 1'b1;
      S_FIX:    cmd.fix = 1'b1;
      S_EMIT:   cmd.emit = st.out_free;
      S_REPORT: begin
        cmd.report  = st.out_free;
        cmd.clr_all = st.out_free && (op_q == OP_CLEAR);
        cmd.ins     = st.out_free && (op_q == OP_INSERT) && st.ins_ok;
      end
      default:  ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_fix_after_shift: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX |-> $past(state) == S_SHIFT) else $error("fix without shift");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_lbl, cmd.zscan, cmd.bfs, cmd.shift, cmd.fix, cmd.emit, cmd.report}))
    else $error("overlapping commands");
endmodule

[rtl/otr_dp.sv]
`timescale 1ns / 1ps
module otr_dp
  import otr_pkg::*;
#(
  parameter int MaxV = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          cmd,
  output stat_t         st,
  input  logic          cfg_we,
  input  logic [5:0]    cfg_data,
  input  logic [1:0]    op_in,
  input  logic [VW-1:0] a_in,
  input  logic [VW-1:0] b_in,
  input  logic [VW-1:0] root_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [VW-1:0] o_vertex,
  output logic [VW-1:0] o_parent,
  output logic          o_has_parent,
  output logic [1:0]    o_status,
  output logic          o_all_deg2,
  output logic [CW-1:0] o_edge_count,
  output logic          o_last
);
  localparam int Slots = MaxV + 1;
  localparam int SW    = $clog2(Slots + 1);
  localparam int FW    = $clog2(MaxV);

  // edge list, read at one address a cycle through a data register
  logic [2*VW-1:0] edges [Slots];
  logic [2*VW-1:0] e_q;             // registered read data
  logic [SW-1:0]   rd_addr;
  logic [SW-1:0]   etot;
  logic [CW-1:0]   deg [MaxV];
  logic [VW-1:0]   par [MaxV];
  logic [MaxV-1:0] pval, vis;
  logic [VW-1:0]   fq [MaxV];      // frontier queue, BFS order
  logic [FW:0]     qh, qt;
  logic [5:0]      vcnt;
  logic [VW-1:0]   a_q, b_q, root_q;
  logic [SW-1:0]   j, j_next;       // edge scan index
  logic [1:0]      found;
  logic [SW-1:0]   p1, skip;
  logic [VW-1:0]   o1;
  logic [2*VW-1:0] e1;              // first edge seen at vertex 0
  logic            has_skip;
  logic [2*VW-1:0] saved;
  logic [VW-1:0]   ev;              // emit vertex
  logic            rbad;

  // used vertex count, saturated
  logic [6:0] n;
  always_comb begin
    if (vcnt == 6'd0) n = 7'd1;
    else if ({1'b0, vcnt} > 7'(MaxV)) n = 7'(MaxV);
    else n = {1'b0, vcnt};
  end

  logic ins_ok_c;
  assign ins_ok_c = ({2'b0, a_q} < n) && ({2'b0, b_q} < n) && (a_q != b_q) &&
                    (7'(etot) < n + 7'd1);

  logic deg2;
  always_comb begin
    deg2 = 1'b1;
    for (int v = 0; v < MaxV; v++)
      if (7'(v) < n && deg[v] != 6'd2) deg2 = 1'b0;
  end

  // degree flag as it will read after a good insert
  logic deg2_after;
  always_comb begin
    deg2_after = 1'b1;
    for (int v = 0; v < MaxV; v++) begin
      logic [CW-1:0] d;
      d = deg[v] + CW'(FW'(v) == a_q[FW-1:0]) + CW'(FW'(v) == b_q[FW-1:0]);
      if (7'(v) < n && d != 6'd2) deg2_after = 1'b0;
    end
  end

  // current edge fields
  logic [VW-1:0] ea, eb, cur_p, oth;
  logic ej_ok, scan_end;
  assign ea = e_q[2*VW-1:VW];
  assign eb = e_q[VW-1:0];
  assign oth = (ea != '0) ? ea : eb;
  assign ej_ok = ({2'b0, ea} < n) && ({2'b0, eb} < n);
  assign scan_end = (j + SW'(1) >= etot) || (etot == '0);
  assign cur_p = fq[qh[FW-1:0]];

  assign st.ins_ok     = ins_ok_c;
  assign st.root_bad   = !({2'b0, root_q} < n);
  assign st.zscan_done = (etot != SW'(n)) || scan_end || (found == 2'd2);
  assign st.bfs_done   = (qh == qt);
  assign st.do_shift   = has_skip && (skip < etot);
  assign st.shift_done = (j + SW'(2) >= etot);
  assign st.emit_last  = (7'(ev) + 7'd1 == n);
  assign st.out_free   = !out_valid || out_ready;

  // advance the scan index
  always_comb begin
    j_next = j;
    if (cmd.clr_lbl) j_next = '0;
    if (cmd.zscan) begin
      if (etot == SW'(n) && etot != '0 && found != 2'd2) j_next = j + SW'(1);
      if (st.zscan_done) j_next = '0;
    end
    if (cmd.bfs) begin
      if (qh != qt) j_next = scan_end ? '0 : j + SW'(1);
      else if (st.do_shift) j_next = skip;
    end
    if (cmd.shift) j_next = j + SW'(1);
  end

  // compaction reads one entry ahead of the index
  assign rd_addr = (cmd.shift || (cmd.bfs && qh == qt)) ? j_next + SW'(1) : j_next;

  always_ff @(posedge clk) begin
    e_q <= edges[rd_addr[$clog2(Slots)-1:0]];
    if (rst) begin
      etot <= '0; pval <= '0; vis <= '0; vcnt <= 6'd32;
      out_valid <= 1'b0;
      qh <= '0; qt <= '0; j <= '0;
      for (int v = 0; v < MaxV; v++) deg[v] <= '0;
    end else begin
      j <= j_next;
      if (cfg_we) vcnt <= cfg_data;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.take) begin
        a_q <= a_in; b_q <= b_in; root_q <= root_in;
      end
      if (cmd.clr_all) begin
        etot <= '0; pval <= '0;
        for (int v = 0; v < MaxV; v++) deg[v] <= '0;
      end
      if (cmd.ins) begin
        edges[etot[$clog2(Slots)-1:0]] <= {a_q, b_q};
        etot <= etot + SW'(1);
        deg[a_q[FW-1:0]] <= deg[a_q[FW-1:0]] + 6'd1;
        deg[b_q[FW-1:0]] <= deg[b_q[FW-1:0]] + 6'd1;
      end
      if (cmd.report) begin
        out_valid <= 1'b1; o_vertex <= '0; o_parent <= '0; o_has_parent <= 1'b0;
        o_last <= 1'b1;
        if (op_in == OP_INSERT && !ins_ok_c) begin
          o_status <= ((({2'b0, a_q} < n) && ({2'b0, b_q} < n) && a_q != b_q))
                      ? ST_FULL : ST_BAD;
        end else o_status <= ST_OK;
        // flag and count after the update
        if (op_in == OP_CLEAR) begin
          o_edge_count <= '0;
          o_all_deg2 <= 1'b0;
        end else if (op_in == OP_INSERT && ins_ok_c) begin
          o_edge_count <= CW'(etot + SW'(1));
          o_all_deg2 <= deg2_after;
        end else begin
          o_edge_count <= CW'(etot);
          o_all_deg2 <= deg2;
        end
      end
      if (cmd.clr_lbl) begin
        pval <= '0;
        vis  <= '0;
        rbad <= !({2'b0, root_q} < n);
        if ({2'b0, root_q} < n) vis[root_q[FW-1:0]] <= 1'b1;
        fq[0] <= root_q;
        qh <= '0; qt <= (FW+1)'(1);
        found <= '0; has_skip <= 1'b0; skip <= '0; ev <= '0;
      end
      // find both edges at vertex 0, set aside the one with the larger neighbor
      if (cmd.zscan) begin
        if (etot == SW'(n) && etot != '0 && found != 2'd2) begin
          if (ej_ok && (ea == '0 || eb == '0)) begin
            if (found == 2'd0) begin
              p1 <= j; o1 <= oth; e1 <= e_q;
            end else begin
              has_skip <= 1'b1;
              if (o1 > oth) begin
                skip <= p1; saved <= e1;
              end else begin
                skip <= j; saved <= e_q;
              end
            end
            found <= found + 2'd1;
          end
        end
      end
      // one edge against the head of the frontier per cycle
      if (cmd.bfs && qh != qt) begin
        if (etot != '0 && !(has_skip && j == skip) && ej_ok) begin
          if (ea == cur_p && !vis[eb[FW-1:0]]) begin
            par[eb[FW-1:0]] <= ea; pval[eb[FW-1:0]] <= 1'b1; vis[eb[FW-1:0]] <= 1'b1;
            fq[qt[FW-1:0]] <= eb; qt <= qt + (FW+1)'(1);
          end else if (eb == cur_p && !vis[ea[FW-1:0]]) begin
            par[ea[FW-1:0]] <= eb; pval[ea[FW-1:0]] <= 1'b1; vis[ea[FW-1:0]] <= 1'b1;
            fq[qt[FW-1:0]] <= ea; qt <= qt + (FW+1)'(1);
          end
        end
        if (scan_end) qh <= qh + (FW+1)'(1);
      end
      // move each later edge down by one
      if (cmd.shift) begin
        if (j + SW'(1) < etot)
          edges[j[$clog2(Slots)-1:0]] <= e_q;
      end
      if (cmd.fix) begin
        edges[etot[$clog2(Slots)-1:0] - 1'b1] <= saved;
        par[0] <= (saved[2*VW-1:VW] != '0) ? saved[2*VW-1:VW] : saved[VW-1:0];
        pval[0] <= 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        o_vertex <= ev;
        o_parent <= pval[ev[FW-1:0]] ? par[ev[FW-1:0]] : '0;
        o_has_parent <= pval[ev[FW-1:0]];
        o_status <= rbad ? ST_BAD : ST_OK;
        o_all_deg2 <= deg2;
        o_edge_count <= CW'(etot);
        o_last <= st.emit_last;
        ev <= ev + VW'(1);
      end
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst)
    qh <= qt) else $error("frontier head passed tail");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    etot <= SW'(Slots)) else $error("edge count overflow");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(o_vertex)) else $error("result dropped");
endmodule

[rtl/one_tree_rooting_engine.sv]
`timescale 1ns / 1ps
// Clear, insert and unused opcodes: one result each, from the report step.
// Root: clear labels, vertex 0 scan of the edges, search (one edge compare per cycle
// against the frontier head), compaction when needed, then one result per vertex.
// One item in flight at a time.
// Synchronous reset empties the edge list, degrees, parents; vertex_count 32.
module one_tree_rooting_engine
  import otr_pkg::*;
#(
  parameter int MAX_VERTICES = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [5:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [4:0] edge_end_a,
  input  logic [4:0] edge_end_b,
  input  logic [4:0] root_vertex,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] vertex,
  output logic [4:0] parent,
  output logic       has_parent,
  output logic [1:0] status,
  output logic       all_degree_two,
  output logic [5:0] edge_count,
  output logic       last
);
  cmd_t  cmd;
  stat_t st;
  opcode_t op_q;

  // hold the opcode of the beat for the report step
  always_ff @(posedge clk) begin
    if (rst) op_q <= OP_NONE;
    else if (cmd.take) op_q <= opcode_t'(opcode);
  end

  otr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .op(opcode_t'(opcode)),
    .st(st), .in_ready(in_ready), .cmd(cmd)
  );

  otr_dp #(.MaxV(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .op_in(op_q), .a_in(edge_end_a), .b_in(edge_end_b), .root_in(root_vertex),
    .out_valid(out_valid), .out_ready(out_ready),
    .o_vertex(vertex), .o_parent(parent), .o_has_parent(has_parent),
    .o_status(status), .o_all_deg2(all_degree_two), .o_edge_count(edge_count),
    .o_last(last)
  );
endmodule
